// ===== hw/rtl/doubly_linked_list_manager_top_macros.svh =====
// Assertion helpers for the list manager.
// Each macro expects clk and rst in scope at the place of use.
`ifndef DOUBLY_LINKED_LIST_MANAGER_TOP_MACROS_SVH
`define DOUBLY_LINKED_LIST_MANAGER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define DLLM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication.
`define DLLM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define DLLM_ASSERT_NOW(lbl, pre, post, msg)
`define DLLM_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== hw/rtl/dllm_pkg.sv =====
`default_nettype none

package dllm_pkg;

  localparam int NODE_COUNT_DEF = 256;

  // Fixed field widths of the channels.
  localparam int KIND_W  = 3;
  localparam int NODE_W  = 8;
  localparam int COUNT_W = 9;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dllm_req_if.sv =====
`default_nettype none

interface dllm_req_if;
  logic                           valid;
  logic                           ready;
  logic [dllm_pkg::KIND_W-1:0]    kind;
  logic [dllm_pkg::NODE_W-1:0]    node;
  logic                           node_present;

  modport source (output valid, kind, node, node_present, input ready);
  modport sink   (input valid, kind, node, node_present, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dllm_rsp_if.sv =====
`default_nettype none

interface dllm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dllm_pkg::NODE_W-1:0]    result_node;
  logic                           result_valid;
  logic [dllm_pkg::COUNT_W-1:0]   node_count;

  modport source (output valid, result_node, result_valid, node_count, input ready);
  modport sink   (input valid, result_node, result_valid, node_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dllm_ram.sv =====
`default_nettype none

module dllm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/doubly_linked_list_manager_top.sv =====
// Channel | Dir | Fields                                   | Item
// --------+-----+------------------------------------------+---------------------------
// req     | in  | kind[2:0], node[7:0], node_present       | one list operation
// rsp     | out | result_node[7:0], result_valid, node_count[8:0] | one answer per request
//
// Each item runs in accept and execute: the accept cycle issues the link reads (and
// the first link write of a push), the execute cycle gets the registered read
// data, writes the neighbors back (a push nulls the node's other link instead)
// and loads the response register. One write port per link memory splits the
// work this way; items run one at a time. Reset (rst, synchronous) empties the
// list: head and tail null, count zero. The link memories are not cleared. req
// drops ready in the execute cycle and while a response waits.
`default_nettype none
`include "doubly_linked_list_manager_top_macros.svh"

module doubly_linked_list_manager_top #(
  parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  dllm_req_if.sink   req,
  dllm_rsp_if.source rsp
);

  localparam int IW = $clog2(NODE_COUNT);      // node index width
  localparam int LW = IW + 1;                  // link width, holds null
  localparam int CW = $clog2(NODE_COUNT + 1);  // count width

  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);
  localparam logic [CW-1:0] CNT_MAX = CW'(NODE_COUNT);

  function automatic logic is_node(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  dllm_pkg::state_t state, state_next;

  logic [LW-1:0] head, head_next;
  logic [LW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;

  // Item held between accept and execute.
  logic [dllm_pkg::KIND_W-1:0] op_kind, op_kind_next;
  logic [IW-1:0]               op_node, op_node_next;
  logic                        op_act, op_act_next;

  // Response register.
  logic                          out_valid;
  logic [dllm_pkg::NODE_W-1:0]   out_node;
  logic                          out_present;
  logic [dllm_pkg::COUNT_W-1:0]  out_count;

  // Link memory ports.
  logic          next_we, prev_we;
  logic [IW-1:0] next_waddr, prev_waddr, rd_addr;
  logic [LW-1:0] next_wdata, prev_wdata;
  logic [LW-1:0] next_rdata, prev_rdata;

  logic          acc;
  logic          req_given;
  logic [IW-1:0] req_e;
  logic [LW-1:0] res;

  assign acc       = req.valid && req.ready;
  assign req_given = req.node_present && (32'(req.node) < 32'(NODE_COUNT));
  assign req_e     = IW'(req.node);

  dllm_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rdata)
  );

  dllm_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dllm_pkg::ST_IDLE: begin
        if (acc) begin
          state_next = dllm_pkg::ST_EXEC;
        end
      end
      dllm_pkg::ST_EXEC: begin
        state_next = dllm_pkg::ST_IDLE;
      end
      default: state_next = dllm_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs: take a new item once the response slot frees up.
  always_comb begin
    req.ready = (state == dllm_pkg::ST_IDLE) && (!out_valid || rsp.ready);
    rsp.valid        = out_valid;
    rsp.result_node  = out_node;
    rsp.result_valid = out_present;
    rsp.node_count   = out_count;
  end

  // Link datapath: reads and first push write on accept; second push write or unlink on execute.
  always_comb begin
    next_we      = 1'b0;
    next_waddr   = '0;
    next_wdata   = NIL;
    prev_we      = 1'b0;
    prev_waddr   = '0;
    prev_wdata   = NIL;
    rd_addr      = req_e;
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    res          = NIL;
    op_kind_next = op_kind;
    op_node_next = op_node;
    op_act_next  = op_act;

    unique case (state)
      dllm_pkg::ST_IDLE: begin
        if (acc) begin
          op_kind_next = req.kind;
          op_node_next = req_e;
          op_act_next  = 1'b0;
          unique case (req.kind)
            dllm_pkg::KIND_PUSH_FRONT: begin
              op_act_next = req_given;
              if (req_given) begin
                // next[e] = head covers the empty case, head is null then
                next_we    = 1'b1;
                next_waddr = req_e;
                next_wdata = head;
                if (is_node(head)) begin
                  prev_we    = 1'b1;
                  prev_waddr = head[IW-1:0];
                  prev_wdata = {1'b0, req_e};
                end else begin
                  tail_next = {1'b0, req_e};
                end
                head_next = {1'b0, req_e};
                if (count < CNT_MAX) begin
                  count_next = CW'(count + 1'b1);
                end
              end
            end
            dllm_pkg::KIND_PUSH_BACK: begin
              op_act_next = req_given;
              if (req_given) begin
                prev_we    = 1'b1;
                prev_waddr = req_e;
                prev_wdata = tail;
                if (is_node(tail)) begin
                  next_we    = 1'b1;
                  next_waddr = tail[IW-1:0];
                  next_wdata = {1'b0, req_e};
                end else begin
                  head_next = {1'b0, req_e};
                end
                tail_next = {1'b0, req_e};
                if (count < CNT_MAX) begin
                  count_next = CW'(count + 1'b1);
                end
              end
            end
            dllm_pkg::KIND_REMOVE: begin
              op_act_next = req_given;
              rd_addr     = req_e;
            end
            dllm_pkg::KIND_POP_FRONT: begin
              op_act_next  = is_node(head);
              op_node_next = head[IW-1:0];
              rd_addr      = head[IW-1:0];
            end
            dllm_pkg::KIND_POP_BACK: begin
              op_act_next  = is_node(tail);
              op_node_next = tail[IW-1:0];
              rd_addr      = tail[IW-1:0];
            end
            default: op_act_next = 1'b0;
          endcase
        end
      end

      dllm_pkg::ST_EXEC: begin
        unique case (op_kind) inside
          dllm_pkg::KIND_PUSH_FRONT: begin
            if (op_act) begin
              prev_we    = 1'b1;
              prev_waddr = op_node;
              prev_wdata = NIL;
            end
          end
          dllm_pkg::KIND_PUSH_BACK: begin
            if (op_act) begin
              next_we    = 1'b1;
              next_waddr = op_node;
              next_wdata = NIL;
            end
          end
          dllm_pkg::KIND_REMOVE, dllm_pkg::KIND_POP_FRONT, dllm_pkg::KIND_POP_BACK: begin
            if (op_act) begin
              // Splice the neighbors around the node.
              if (is_node(prev_rdata)) begin
                next_we    = 1'b1;
                next_waddr = prev_rdata[IW-1:0];
                next_wdata = next_rdata;
              end
              if (is_node(next_rdata)) begin
                prev_we    = 1'b1;
                prev_waddr = next_rdata[IW-1:0];
                prev_wdata = prev_rdata;
              end
              if (head == {1'b0, op_node}) begin
                head_next = next_rdata;
              end
              if (tail == {1'b0, op_node}) begin
                tail_next = prev_rdata;
              end
              if (count != '0) begin
                count_next = CW'(count - 1'b1);
              end
              // Remove answers with the successor, pops with the node.
              res = (op_kind == dllm_pkg::KIND_REMOVE) ? next_rdata : {1'b0, op_node};
            end
          end
          default: res = NIL;
        endcase
      end

      default: res = NIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dllm_pkg::ST_IDLE;
      head      <= NIL;
      tail      <= NIL;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (state == dllm_pkg::ST_EXEC) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and response payload: no reset needed.
  always_ff @(posedge clk) begin
    op_kind <= op_kind_next;
    op_node <= op_node_next;
    op_act  <= op_act_next;
    if (state == dllm_pkg::ST_EXEC) begin
      out_node    <= is_node(res) ? dllm_pkg::NODE_W'(res) : '0;
      out_present <= is_node(res);
      out_count   <= dllm_pkg::COUNT_W'(count_next);
    end
  end

  `DLLM_ASSERT_NEXT(a_accept_exec, acc, state == dllm_pkg::ST_EXEC, "accept did not enter execute")
  `DLLM_ASSERT_NEXT(a_exec_resp, state == dllm_pkg::ST_EXEC, out_valid, "execute gave no response")
  `DLLM_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_MAX, "count above pool size")
  `DLLM_ASSERT_NOW(a_no_overrun, state == dllm_pkg::ST_EXEC, !out_valid || rsp.ready, "response overrun")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dllm_pkg::*;

  localparam int POOL = NODE_COUNT_DEF;
  localparam logic [COUNT_W-1:0] NIL = COUNT_W'(POOL);
  localparam int ITEM_TARGET = 1150;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 10;

  // One answer of the block, as the list bookkeeping predicts it.
  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic               hit;
    logic [COUNT_W-1:0] count;
  } answer_t;

  // Stall styles of the answer side.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_COMB,
    RX_HEAVY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  dllm_req_if req_ch ();
  dllm_rsp_if rsp_ch ();

  doubly_linked_list_manager_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow list: links, ends and length as the block should hold them.
  logic [COUNT_W-1:0] fwd_link  [POOL];
  logic [COUNT_W-1:0] back_link [POOL];
  logic [COUNT_W-1:0] list_head;
  logic [COUNT_W-1:0] list_tail;
  logic [COUNT_W-1:0] list_len;
  // A node whose links have been written at least once; only such a node
  // may be removed, so no link store entry is ever read before it is set.
  bit                 linked_once [POOL];

  // Membership as the stimulus sees it; trusted only while the list is sound.
  bit on_list [POOL];
  int members;

  answer_t expected_answers[$];
  int      items_sent;
  int      mismatches;
  int      burst_left;
  bit      steady_send;
  int      quiet_cycles;
  int      rx_tick;
  rx_mode_t rx_mode;

  function automatic bit is_null(input logic [COUNT_W-1:0] x);
    return x >= COUNT_W'(POOL);
  endfunction

  // Take a node out of its neighbors' links and off the ends.
  function automatic void detach_node(input logic [NODE_W-1:0] node);
    logic [COUNT_W-1:0] succ;
    logic [COUNT_W-1:0] pred;
    succ = fwd_link[node];
    pred = back_link[node];
    if (!is_null(succ)) back_link[succ[NODE_W-1:0]] = pred;
    if (!is_null(pred)) fwd_link[pred[NODE_W-1:0]] = succ;
    if (list_head == {1'b0, node}) list_head = succ;
    if (list_tail == {1'b0, node}) list_tail = pred;
    if (list_len != 0) list_len = list_len - 1'b1;
  endfunction

  // Apply one operation to the shadow list and return the answer it gives.
  function automatic answer_t list_model_step(input logic [KIND_W-1:0] op,
                                              input logic [NODE_W-1:0] node,
                                              input logic present);
    answer_t ans;
    logic [COUNT_W-1:0] e;
    logic [COUNT_W-1:0] res;
    e = {1'b0, node};
    res = NIL;
    case (op)
      KIND_PUSH_FRONT: begin
        if (present) begin
          if (is_null(list_head)) begin
            list_head = e;
            list_tail = e;
            fwd_link[node] = NIL;
            back_link[node] = NIL;
          end else begin
            back_link[list_head[NODE_W-1:0]] = e;
            back_link[node] = NIL;
            fwd_link[node] = list_head;
            list_head = e;
          end
          linked_once[node] = 1'b1;
          if (list_len < COUNT_W'(POOL)) list_len = list_len + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (present) begin
          if (is_null(list_tail)) begin
            list_head = e;
            list_tail = e;
            fwd_link[node] = NIL;
            back_link[node] = NIL;
          end else begin
            fwd_link[list_tail[NODE_W-1:0]] = e;
            back_link[node] = list_tail;
            fwd_link[node] = NIL;
            list_tail = e;
          end
          linked_once[node] = 1'b1;
          if (list_len < COUNT_W'(POOL)) list_len = list_len + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (present) begin
          detach_node(node);
          // the successor is read after the unlink, aliasing included
          res = fwd_link[node];
        end
      end
      KIND_POP_FRONT: begin
        if (!is_null(list_head)) begin
          res = list_head;
          detach_node(res[NODE_W-1:0]);
        end
      end
      KIND_POP_BACK: begin
        if (!is_null(list_tail)) begin
          res = list_tail;
          detach_node(res[NODE_W-1:0]);
        end
      end
      default: begin
      end
    endcase
    ans.hit = !is_null(res);
    ans.node = ans.hit ? res[NODE_W-1:0] : '0;
    ans.count = list_len;
    return ans;
  endfunction

  // Send one operation; predict its answer once the block takes it.
  task automatic send_op(input logic [KIND_W-1:0] op, input logic [NODE_W-1:0] node,
                         input logic present, output answer_t ans);
    int gap;
    // Open a new burst with a random gap in front, unless sending steadily.
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= op;
    req_ch.node         <= node;
    req_ch.node_present <= present;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ans = list_model_step(op, node, present);
    expected_answers.push_back(ans);
    items_sent++;
    // Track membership for the stimulus.
    if (present && (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) && !on_list[node]) begin
      on_list[node] = 1'b1;
      members++;
    end
    if (present && op == KIND_REMOVE && on_list[node]) begin
      on_list[node] = 1'b0;
      members--;
    end
    if ((op == KIND_POP_FRONT || op == KIND_POP_BACK) && ans.hit && on_list[ans.node]) begin
      on_list[ans.node] = 1'b0;
      members--;
    end
  endtask

  // Find a node on or off the list, starting at a random index; -1 if none.
  function automatic int pick_node(input bit want_on, input bit need_written);
    int start;
    int n;
    start = $urandom_range(0, POOL - 1);
    for (int k = 0; k < POOL; k++) begin
      n = (start + k) % POOL;
      if (on_list[n] == want_on && (!need_written || linked_once[n])) return n;
    end
    return -1;
  endfunction

  // Bring any state, however tangled, back to an empty list with count zero.
  task automatic untangle_list();
    logic [NODE_W-1:0] spare;
    answer_t ans;
    spare = NODE_W'($urandom_range(0, POOL - 1));
    // With both ends set, make spare the head with no successor and drop it:
    // that leaves the head null.
    if (!is_null(list_head) && !is_null(list_tail)) begin
      send_op(KIND_PUSH_FRONT, spare, 1'b1, ans);
      send_op(KIND_PUSH_BACK, spare, 1'b1, ans);
      send_op(KIND_REMOVE, spare, 1'b1, ans);
    end
    // One end is null: the push takes the empty-list path and resets both ends.
    send_op(is_null(list_head) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, spare, 1'b1, ans);
    send_op(KIND_REMOVE, spare, 1'b1, ans);
    // spare now has null links; removing it again only lowers the count.
    while (list_len != 0) send_op(KIND_REMOVE, spare, 1'b1, ans);
    for (int k = 0; k < POOL; k++) on_list[k] = 1'b0;
    members = 0;
  endtask

  // Pops on an empty list, missing nodes and unused operation codes.
  task automatic test_empty_list();
    answer_t ans;
    send_op(KIND_POP_FRONT, NODE_W'($urandom), 1'b1, ans);
    send_op(KIND_POP_BACK, NODE_W'($urandom), 1'b0, ans);
    send_op(KIND_REMOVE, '1, 1'b0, ans);
    send_op(KIND_PUSH_FRONT, '1, 1'b0, ans);
    send_op(KIND_PUSH_BACK, '0, 1'b0, ans);
    for (int k = KIND_POP_BACK + 1; k < (1 << KIND_W); k++)
      send_op(KIND_W'(k), NODE_W'($urandom), 1'b1, ans);
  endtask

  // Every operation on a short list, with the lowest and highest node index.
  task automatic test_basic_ops();
    answer_t ans;
    send_op(KIND_PUSH_BACK, 8'h00, 1'b1, ans);
    send_op(KIND_PUSH_FRONT, 8'hFF, 1'b1, ans);
    send_op(KIND_PUSH_BACK, 8'h55, 1'b1, ans);
    send_op(KIND_PUSH_FRONT, 8'hAA, 1'b1, ans);
    send_op(KIND_REMOVE, 8'hFF, 1'b1, ans);
    send_op(KIND_REMOVE, 8'h55, 1'b1, ans);
    send_op(KIND_POP_FRONT, 8'h00, 1'b0, ans);
    send_op(KIND_POP_BACK, 8'hFF, 1'b1, ans);
    send_op(KIND_POP_FRONT, 8'h12, 1'b1, ans);
    send_op(KIND_POP_BACK, 8'h34, 1'b0, ans);
  endtask

  // Push a node already on the list, remove one that is off it, then try to
  // lower the count below zero; it stays at zero.
  task automatic test_misuse();
    answer_t ans;
    send_op(KIND_PUSH_BACK, 8'd7, 1'b1, ans);
    send_op(KIND_PUSH_BACK, 8'd9, 1'b1, ans);
    send_op(KIND_PUSH_FRONT, 8'd9, 1'b1, ans);
    send_op(KIND_REMOVE, 8'hAA, 1'b1, ans);
    untangle_list();
    send_op(KIND_PUSH_FRONT, 8'd3, 1'b1, ans);
    send_op(KIND_REMOVE, 8'd3, 1'b1, ans);
    send_op(KIND_REMOVE, 8'd3, 1'b1, ans);
  endtask

  // Fill the whole pool, push once more so the count saturates, then drain.
  task automatic test_pool_saturation();
    int order [POOL];
    int j;
    int tmp;
    int guard;
    answer_t ans;
    for (int k = 0; k < POOL; k++) order[k] = k;
    for (int k = POOL - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < POOL; k++)
      send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
              NODE_W'(order[k]), 1'b1, ans);
    // The tail pushed again keeps the forward chain intact, so pops still walk it.
    send_op(KIND_PUSH_BACK, list_tail[NODE_W-1:0], 1'b1, ans);
    guard = 0;
    while (!is_null(list_head) && guard < 2 * POOL) begin
      send_op(KIND_POP_FRONT, NODE_W'($urandom), 1'($urandom), ans);
      guard++;
    end
    untangle_list();
  endtask

  // Segments of mostly sound traffic with a changing push share; some noise
  // and now and then a misuse, after which the list is rebuilt from empty.
  task automatic test_random_traffic();
    int seg_len;
    int push_bias;
    int n;
    int r;
    answer_t ans;
    while (items_sent < ITEM_TARGET) begin
      seg_len = $urandom_range(20, 60);
      push_bias = $urandom_range(25, 80);
      steady_send = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        if (r < 86) begin
          if ($urandom_range(0, 99) < push_bias && members < POOL) begin
            n = pick_node(1'b0, 1'b0);
            send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                    NODE_W'(n), 1'b1, ans);
          end else if ($urandom_range(0, 2) == 0 && members > 0) begin
            n = pick_node(1'b1, 1'b0);
            send_op(KIND_REMOVE, NODE_W'(n), 1'b1, ans);
          end else begin
            send_op($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK,
                    NODE_W'($urandom), 1'($urandom), ans);
          end
        end else if (r < 96) begin
          case ($urandom_range(0, 2))
            0: send_op(KIND_W'(KIND_POP_BACK + $urandom_range(1, 3)),
                       NODE_W'($urandom), 1'($urandom), ans);
            1: send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                       NODE_W'($urandom), 1'b0, ans);
            default: send_op(KIND_REMOVE, NODE_W'($urandom), 1'b0, ans);
          endcase
        end else begin
          if (members > 0 && $urandom_range(0, 1)) begin
            n = pick_node(1'b1, 1'b0);
            send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                    NODE_W'(n), 1'b1, ans);
          end else begin
            n = pick_node(1'b0, 1'b1);
            if (n >= 0) send_op(KIND_REMOVE, NODE_W'(n), 1'b1, ans);
          end
          untangle_list();
        end
      end
    end
    steady_send = 1'b0;
  endtask

  // Answer side: stall in one of four styles, chosen anew at random by rx_tick.
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 200 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  rsp_ch.ready <= 1'b1;
      RX_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_COMB:  rsp_ch.ready <= ((rx_tick % 7) < 4);
      default:  rsp_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Compare each answer taken with the oldest prediction.
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $error("answer with nothing outstanding: node %0d hit %0b count %0d",
               rsp_ch.result_node, rsp_ch.result_valid, rsp_ch.node_count);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        if (rsp_ch.result_node !== want.node) begin
          $error("result_node: expected %0d, got %0d", want.node, rsp_ch.result_node);
          mismatches++;
        end
        if (rsp_ch.result_valid !== want.hit) begin
          $error("result_valid: expected %0b, got %0b", want.hit, rsp_ch.result_valid);
          mismatches++;
        end
        if (rsp_ch.node_count !== want.count) begin
          $error("node_count: expected %0d, got %0d", want.count, rsp_ch.node_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = '0;
    req_ch.node         = '0;
    req_ch.node_present = 1'b0;
    rsp_ch.ready        = 1'b0;
    rx_mode             = RX_OPEN;
    for (int k = 0; k < POOL; k++) begin
      fwd_link[k]    = '0;
      back_link[k]   = '0;
      linked_once[k] = 1'b0;
      on_list[k]     = 1'b0;
    end
    list_head = NIL;
    list_tail = NIL;
    list_len  = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_basic_ops();
    test_misuse();
    test_pool_saturation();
    test_random_traffic();

    // Drop valid, wait out the outstanding answers, then let the pipe settle.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
